>>> rtl/ogbs_pkg.sv
package ogbs_pkg;

  localparam int GLYPH_COUNT = 68;
  localparam int IDX_W       = 7;
  localparam int BYTE_W      = 8;

  typedef logic [IDX_W-1:0]  glyph_idx_t;
  typedef logic [3:0]        beat_t;
  typedef logic [39:0]       glyph_row_t;

  // byte positions within one character transaction group
  localparam beat_t BEAT_PAGE   = 4'd0;
  localparam beat_t BEAT_COL_LO = 4'd1;
  localparam beat_t BEAT_COL_HI = 4'd2;
  localparam beat_t BEAT_G0     = 4'd3;
  localparam beat_t BEAT_G1     = 4'd4;
  localparam beat_t BEAT_G2     = 4'd5;
  localparam beat_t BEAT_G3     = 4'd6;
  localparam beat_t BEAT_G4     = 4'd7;
  localparam beat_t BEAT_LAST   = 4'd8;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;
  localparam logic [1:0] COL_OFS_RESET = 2'd2;

  localparam glyph_idx_t IDX_SPACE  = 7'd0;
  localparam glyph_idx_t IDX_BANG   = 7'd1;
  localparam glyph_idx_t IDX_UPPER  = 7'd2;
  localparam glyph_idx_t IDX_LOWER  = 7'd28;
  localparam glyph_idx_t IDX_DIGIT  = 7'd54;
  localparam glyph_idx_t IDX_COLON  = 7'd64;
  localparam glyph_idx_t IDX_DASH   = 7'd65;
  localparam glyph_idx_t IDX_DOT    = 7'd66;
  localparam glyph_idx_t IDX_DEGREE = 7'd67;

  // item handed from the sequencer to the output formatter
  typedef struct packed {
    logic       valid;
    beat_t      beat;
    glyph_idx_t idx;
    logic [7:0] addr;
    logic [2:0] page;
  } item_t;

  function automatic glyph_idx_t char_to_idx(input logic [7:0] ch);
    glyph_idx_t idx;
    idx = IDX_SPACE;
    if (ch == 8'h21) idx = IDX_BANG;
    else if (ch >= 8'h41 && ch <= 8'h5A) idx = IDX_UPPER + glyph_idx_t'(ch - 8'h41);
    else if (ch >= 8'h61 && ch <= 8'h7A) idx = IDX_LOWER + glyph_idx_t'(ch - 8'h61);
    else if (ch >= 8'h30 && ch <= 8'h39) idx = IDX_DIGIT + glyph_idx_t'(ch - 8'h30);
    else if (ch == 8'h3A) idx = IDX_COLON;
    else if (ch == 8'h2D) idx = IDX_DASH;
    else if (ch == 8'h2E) idx = IDX_DOT;
    else if (ch == 8'h5E) idx = IDX_DEGREE;
    return idx;
  endfunction

  // five columns, leftmost in the top byte
  function automatic glyph_row_t glyph_row(input glyph_idx_t idx);
    glyph_row_t row;
    case (idx)
      7'd0:  row = 40'h00_00_00_00_00;
      7'd1:  row = 40'h00_00_5F_00_00;
      7'd2:  row = 40'h7E_11_11_11_7E;
      7'd3:  row = 40'h7F_49_49_49_36;
      7'd4:  row = 40'h3E_41_41_41_22;
      7'd5:  row = 40'h7F_41_41_22_1C;
      7'd6:  row = 40'h7F_49_49_49_41;
      7'd7:  row = 40'h7F_09_09_09_01;
      7'd8:  row = 40'h3E_41_49_49_7A;
      7'd9:  row = 40'h7F_08_08_08_7F;
      7'd10: row = 40'h00_41_7F_41_00;
      7'd11: row = 40'h20_40_41_3F_01;
      7'd12: row = 40'h7F_08_14_22_41;
      7'd13: row = 40'h7F_40_40_40_40;
      7'd14: row = 40'h7F_02_04_02_7F;
      7'd15: row = 40'h7F_04_08_10_7F;
      7'd16: row = 40'h3E_41_41_41_3E;
      7'd17: row = 40'h7F_09_09_09_06;
      7'd18: row = 40'h3E_41_51_21_5E;
      7'd19: row = 40'h7F_09_19_29_46;
      7'd20: row = 40'h46_49_49_49_31;
      7'd21: row = 40'h01_01_7F_01_01;
      7'd22: row = 40'h3F_40_40_40_3F;
      7'd23: row = 40'h1F_20_40_20_1F;
      7'd24: row = 40'h7F_20_18_20_7F;
      7'd25: row = 40'h63_14_08_14_63;
      7'd26: row = 40'h03_04_78_04_03;
      7'd27: row = 40'h61_51_49_45_43;
      7'd28: row = 40'h20_54_54_54_78;
      7'd29: row = 40'h7F_48_44_44_38;
      7'd30: row = 40'h38_44_44_44_20;
      7'd31: row = 40'h38_44_44_48_7F;
      7'd32: row = 40'h38_54_54_54_18;
      7'd33: row = 40'h08_7E_09_01_02;
      7'd34: row = 40'h0C_52_52_52_3E;
      7'd35: row = 40'h7F_08_04_04_78;
      7'd36: row = 40'h00_44_7D_40_00;
      7'd37: row = 40'h20_40_44_3D_00;
      7'd38: row = 40'h7F_10_28_44_00;
      7'd39: row = 40'h00_41_7F_40_00;
      7'd40: row = 40'h7C_04_18_04_78;
      7'd41: row = 40'h7C_08_04_04_78;
      7'd42: row = 40'h38_44_44_44_38;
      7'd43: row = 40'h7C_14_14_14_08;
      7'd44: row = 40'h08_14_14_18_7C;
      7'd45: row = 40'h7C_08_04_04_08;
      7'd46: row = 40'h48_54_54_54_20;
      7'd47: row = 40'h04_3F_44_40_20;
      7'd48: row = 40'h3C_40_40_20_7C;
      7'd49: row = 40'h1C_20_40_20_1C;
      7'd50: row = 40'h3C_40_30_40_3C;
      7'd51: row = 40'h44_28_10_28_44;
      7'd52: row = 40'h0C_50_50_50_3C;
      7'd53: row = 40'h44_64_54_4C_44;
      7'd54: row = 40'h3E_51_49_45_3E;
      7'd55: row = 40'h00_42_7F_40_00;
      7'd56: row = 40'h42_61_51_49_46;
      7'd57: row = 40'h21_41_45_4B_31;
      7'd58: row = 40'h18_14_12_7F_10;
      7'd59: row = 40'h27_45_45_45_39;
      7'd60: row = 40'h3C_4A_49_49_30;
      7'd61: row = 40'h01_71_09_05_03;
      7'd62: row = 40'h36_49_49_49_36;
      7'd63: row = 40'h06_49_49_29_1E;
      7'd64: row = 40'h00_36_36_00_00;
      7'd65: row = 40'h00_08_08_08_00;
      7'd66: row = 40'h00_60_60_00_00;
      7'd67: row = 40'h06_09_09_06_00;
      default: row = 40'h00_00_00_00_00;
    endcase
    return row;
  endfunction

endpackage

>>> rtl/ogbs_seq.sv
module ogbs_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_char_code,
  input  logic [6:0]         in_start_column,
  input  logic [2:0]         in_page_index,
  input  logic [1:0]         col_ofs,
  output ogbs_pkg::item_t    item
);

  logic                 accept;
  logic                 active_r, active_nxt;
  ogbs_pkg::beat_t      beat_r, beat_nxt;
  ogbs_pkg::glyph_idx_t idx_r;
  logic [7:0]           addr_r;
  logic [2:0]           page_r;

  // free again while the last byte of the current character is handed on
  assign busy   = active_r && (beat_r != ogbs_pkg::BEAT_LAST);
  assign accept = start && !busy;

  always_comb begin
    active_nxt = active_r;
    beat_nxt   = beat_r;
    if (accept) begin
      active_nxt = 1'b1;
      beat_nxt   = ogbs_pkg::BEAT_PAGE;
    end else if (active_r) begin
      if (beat_r == ogbs_pkg::BEAT_LAST) begin
        active_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      beat_r   <= ogbs_pkg::BEAT_PAGE;
    end else begin
      active_r <= active_nxt;
      beat_r   <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r  <= ogbs_pkg::char_to_idx(in_char_code);
      addr_r <= {1'b0, in_start_column} + {6'd0, col_ofs};
      page_r <= in_page_index;
    end
  end

  assign item.valid = active_r;
  assign item.beat  = beat_r;
  assign item.idx   = idx_r;
  assign item.addr  = addr_r;
  assign item.page  = page_r;

endmodule

>>> rtl/ogbs_fmt.sv
module ogbs_fmt (
  input  logic            clk,
  input  logic            rst_n,
  input  ogbs_pkg::item_t item,
  output logic            out_valid,
  output logic            out_is_data,
  output logic [7:0]      out_byte,
  output logic            out_last_byte
);

  ogbs_pkg::glyph_row_t row;
  logic                 valid_r;
  logic                 is_data_r, is_data_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;

  assign row = ogbs_pkg::glyph_row(item.idx);

  always_comb begin
    is_data_nxt = 1'b1;
    byte_nxt    = 8'h00;
    last_nxt    = 1'b0;
    unique case (item.beat)
      ogbs_pkg::BEAT_PAGE: begin
        is_data_nxt = 1'b0;
        byte_nxt    = ogbs_pkg::PAGE_CMD_BASE + {5'd0, item.page};
      end
      ogbs_pkg::BEAT_COL_LO: begin
        is_data_nxt = 1'b0;
        byte_nxt    = {4'h0, item.addr[3:0]};
      end
      ogbs_pkg::BEAT_COL_HI: begin
        is_data_nxt = 1'b0;
        byte_nxt    = ogbs_pkg::COL_HI_CMD | {4'h0, item.addr[7:4]};
      end
      ogbs_pkg::BEAT_G0: byte_nxt = row[39:32];
      ogbs_pkg::BEAT_G1: byte_nxt = row[31:24];
      ogbs_pkg::BEAT_G2: byte_nxt = row[23:16];
      ogbs_pkg::BEAT_G3: byte_nxt = row[15:8];
      ogbs_pkg::BEAT_G4: byte_nxt = row[7:0];
      ogbs_pkg::BEAT_LAST: last_nxt = 1'b1;
      default: begin
        is_data_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    is_data_r <= is_data_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_is_data   = is_data_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;

endmodule

>>> rtl/oled_glyph_byte_streamer_unit.sv
// 5x7 character byte streamer for a page-addressed OLED controller. Each
// transaction on the input side (start high while busy is low) takes a
// character code, a start column and a page, and produces nine output
// bytes on consecutive cycles, each marked by out_valid: page select,
// column low nibble, column high nibble (commands, out_is_data low), five
// glyph columns and a blank spacing column (data), with out_last_byte on
// the ninth. The receiver cannot stall: every strobed byte must be taken
// in that very cycle. busy drops during the eighth byte of the current
// character so the next one can follow with no gap. A taken character
// passes the sequencer's input and counter registers and then the
// formatter's result register before its first byte is strobed. Codes
// outside the font (including every code of 128 and above) draw a space.
// column_offset (reset 2) is written through cfg_valid/cfg_data, always
// ready, and must only be changed while no character is in flight.
module oled_glyph_byte_streamer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // character input
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_start_column,
  input  logic [2:0] in_page_index,
  // byte stream out
  output logic       out_valid,
  output logic       out_is_data,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  // column offset register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic [1:0]      col_ofs_r;
  ogbs_pkg::item_t item;

  // register write port never pushes back
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_ofs_r <= ogbs_pkg::COL_OFS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      col_ofs_r <= cfg_data;
    end
  end

  // input register plus byte counter; the column offset is folded in at
  // acceptance so the address is fixed for the whole character
  ogbs_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_char_code    (in_char_code),
    .in_start_column (in_start_column),
    .in_page_index   (in_page_index),
    .col_ofs         (col_ofs_r),
    .item            (item)
  );

  // font lookup and byte select into the result register
  ogbs_fmt u_fmt (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (item),
    .out_valid     (out_valid),
    .out_is_data   (out_is_data),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

>>> dv/ogbs_byte_checker.sv
module ogbs_byte_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_start_column,
  input  logic [2:0] in_page_index,
  input  logic       out_valid,
  input  logic       out_is_data,
  input  logic [7:0] out_byte,
  input  logic       out_last_byte,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  // 5x7 font, leftmost column in the top byte
  localparam logic [39:0] FONT_COLS [0:67] = '{
    40'h0000000000, 40'h00005F0000, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
    40'h7F08142241, 40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F,
    40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E, 40'h7F08040478,
    40'h00447D4000, 40'h2040443D00, 40'h7F10284400, 40'h00417F4000,
    40'h7C04180478, 40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844,
    40'h0C5050503C, 40'h4464544C44, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10, 40'h2745454539,
    40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
    40'h0036360000, 40'h0008080800, 40'h0060600000, 40'h0609090600
  };

  stream_byte_t expected_bytes[$];
  logic [1:0]   col_offset;

  // font slot for a character code; anything outside the font draws a space
  function automatic int font_slot(input logic [7:0] ch);
    if (ch == 8'h21) return 1;
    if (ch >= 8'h41 && ch <= 8'h5A) return 2 + int'(ch - 8'h41);
    if (ch >= 8'h61 && ch <= 8'h7A) return 28 + int'(ch - 8'h61);
    if (ch >= 8'h30 && ch <= 8'h39) return 54 + int'(ch - 8'h30);
    if (ch == 8'h3A) return 64;
    if (ch == 8'h2D) return 65;
    if (ch == 8'h2E) return 66;
    if (ch == 8'h5E) return 67;
    return 0;
  endfunction

  function automatic stream_byte_t mk(input logic d, input logic [7:0] v, input logic l);
    stream_byte_t b;
    b.is_data = d;
    b.value   = v;
    b.last    = l;
    return b;
  endfunction

  task automatic queue_char_bytes(input logic [7:0] ch, input logic [6:0] col,
                                  input logic [2:0] pg);
    logic [7:0]  addr;
    logic [39:0] cols;
    addr = {1'b0, col} + {6'd0, col_offset};
    cols = FONT_COLS[font_slot(ch)];
    expected_bytes.push_back(mk(1'b0, ogbs_pkg::PAGE_CMD_BASE + {5'd0, pg}, 1'b0));
    expected_bytes.push_back(mk(1'b0, {4'h0, addr[3:0]}, 1'b0));
    expected_bytes.push_back(mk(1'b0, ogbs_pkg::COL_HI_CMD | {4'h0, addr[7:4]}, 1'b0));
    for (int k = 0; k < 5; k++)
      expected_bytes.push_back(mk(1'b1, cols[39-8*k -: 8], 1'b0));
    expected_bytes.push_back(mk(1'b1, 8'h00, 1'b1));
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] byte check: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    col_offset = ogbs_pkg::COL_OFS_RESET;
  end

  always @(posedge clk) begin
    stream_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      col_offset = ogbs_pkg::COL_OFS_RESET;
    end else begin
      if (out_valid) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %h (data=%b last=%b)",
                                  out_byte, out_is_data, out_last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_is_data !== want.is_data)
            flag_mismatch($sformatf("is_data %b, want %b", out_is_data, want.is_data));
          if (out_byte !== want.value)
            flag_mismatch($sformatf("byte %h, want %h", out_byte, want.value));
          if (out_last_byte !== want.last)
            flag_mismatch($sformatf("last_byte %b, want %b", out_last_byte, want.last));
        end
      end
      if (start && !busy)
        queue_char_bytes(in_char_code, in_start_column, in_page_index);
      if (cfg_valid && cfg_ready)
        col_offset = cfg_data;
    end
    pending = expected_bytes.size();
  end

endmodule

>>> dv/oled_glyph_byte_streamer_unit_tb.sv
module oled_glyph_byte_streamer_unit_tb;

  // cycles with no transaction on any channel before the run is called hung
  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_char_code;
  logic [6:0] in_start_column;
  logic [2:0] in_page_index;
  logic       out_valid;
  logic       out_is_data;
  logic [7:0] out_byte;
  logic       out_last_byte;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;

  int fail_count;
  int pending;
  int gap_pct;
  int quiet_cycles;

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  oled_glyph_byte_streamer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_char_code    (in_char_code),
    .in_start_column (in_start_column),
    .in_page_index   (in_page_index),
    .out_valid       (out_valid),
    .out_is_data     (out_is_data),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // predicts the nine-byte group per character and compares every strobe
  ogbs_byte_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_char_code    (in_char_code),
    .in_start_column (in_start_column),
    .in_page_index   (in_page_index),
    .out_valid       (out_valid),
    .out_is_data     (out_is_data),
    .out_byte        (out_byte),
    .out_last_byte   (out_last_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Watchdog: any transaction (char, byte strobe, cfg write) resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One character transaction. Called right after the previous acceptance
  // edge, so the next falling edge either drops start (gap) or presents the
  // new character -- start never gets two updates in one step. Back-to-back
  // calls keep start high, which is how the no-gap streaming case is hit.
  task automatic send_char(input logic [7:0] ch, input logic [6:0] col,
                           input logic [2:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_char_code    <= ch;
    in_start_column <= col;
    in_page_index   <= pg;
    // busy read in the active region is the pre-edge value
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start, then wait for every predicted byte to drain. Each character
  // always yields bytes, so a short settle after the last one is enough.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  // Column offset write; only issued from an idle block.
  task automatic write_col_offset(input logic [1:0] ofs);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ofs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random character: mostly printable (hits the font), rest anywhere in
  // 0..255. Columns lean on the edges so offset carry into the high nibble
  // and the 130 ceiling come up often.
  task automatic send_random(input int count);
    logic [7:0] ch;
    logic [6:0] col;
    int         pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      ch   = (pick < 60) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
      pick = $urandom_range(99);
      if (pick < 10)      col = 7'd127;
      else if (pick < 20) col = 7'd0;
      else                col = 7'($urandom_range(0, 127));
      send_char(ch, col, 3'($urandom_range(0, 7)));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_char_code    = 8'h00;
    in_start_column = 7'd0;
    in_page_index   = 3'd0;
    cfg_valid       = 1'b0;
    cfg_data        = 2'd0;
    gap_pct         = 0;
    quiet_cycles    = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset offset (2), streaming with no gaps:
    // every font class, its boundaries, and the unmapped neighbors.
    send_char(8'h20, 7'd0,   3'd0);   // space
    send_char(8'h21, 7'd127, 3'd7);   // '!', widest column, last page
    send_char(8'h41, 7'd13,  3'd1);   // 'A'
    send_char(8'h5A, 7'd14,  3'd2);   // 'Z'
    send_char(8'h61, 7'd30,  3'd3);   // 'a'
    send_char(8'h7A, 7'd126, 3'd4);   // 'z'
    send_char(8'h30, 7'd62,  3'd5);   // '0'
    send_char(8'h39, 7'd63,  3'd6);   // '9'
    send_char(8'h3A, 7'd64,  3'd7);   // ':'
    send_char(8'h2D, 7'd1,   3'd0);   // '-'
    send_char(8'h2E, 7'd85,  3'd2);   // '.'
    send_char(8'h5E, 7'd42,  3'd5);   // '^' -> degree sign
    // unmapped: all draw space
    send_char(8'h00, 7'd0,   3'd0);
    send_char(8'hFF, 7'd127, 3'd7);
    send_char(8'h7F, 7'd77,  3'd3);
    send_char(8'h80, 7'd50,  3'd4);
    send_char(8'h40, 7'd10,  3'd1);   // just below 'A'
    send_char(8'h5B, 7'd11,  3'd6);   // just above 'Z'
    send_char(8'h60, 7'd100, 3'd2);   // just below 'a'
    send_char(8'h7B, 7'd101, 3'd5);   // just above 'z'
    send_char(8'h2F, 7'd46,  3'd1);   // just below '0'
    send_char(8'h3B, 7'd93,  3'd6);   // just above ':'

    // Largest offset: 127 + 3 = 130 is the column ceiling.
    write_col_offset(2'd3);
    send_char(8'h5E, 7'd127, 3'd7);
    send_char(8'h4D, 7'd125, 3'd0);
    gap_pct = 32;
    send_random(70);

    // Zero offset, heavier sender gaps.
    write_col_offset(2'd0);
    send_char(8'h57, 7'd127, 3'd7);
    send_char(8'h00, 7'd0,   3'd0);
    gap_pct = 45;
    send_random(70);

    // Offset 1, then back to the reset value, no gaps at all.
    write_col_offset(2'd1);
    gap_pct = 0;
    send_random(35);
    write_col_offset(2'd2);
    send_random(25);

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (12) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> oled_glyph_byte_streamer_unit.f
rtl/ogbs_pkg.sv
rtl/ogbs_seq.sv
rtl/ogbs_fmt.sv
rtl/oled_glyph_byte_streamer_unit.sv
dv/ogbs_byte_checker.sv
dv/oled_glyph_byte_streamer_unit_tb.sv
